// File: src/bresenham_line_rasterizer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line rasterizer
// Immediate-consequence and next-cycle property macros, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define BRL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rasterizer assertion failed");
// Antecedent implies consequent in the next cycle.
`define BRL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rasterizer assertion failed");
`else
`define BRL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BRL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/brl_pkg.sv
// ---------------------------------------------------------------------------
// Line rasterizer package
// Widths, sequencer states, register indexes and the walk descriptor.
// ---------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int ERR_W   = 8;
    localparam int IDX_W   = 12;
    localparam int COLOR_W = 8;
    localparam int TDATA_W = 56;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    // Everything the step loop needs once the endpoints are ordered.
    typedef struct packed {
        logic               steep;
        logic               dir_up;
        logic               zero;
        logic [COORD_W-1:0] major_start;
        logic [COORD_W-1:0] major_end;
        logic [COORD_W-1:0] minor_start;
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W-1:0] dmin;
    } walk_t;

endpackage

`default_nettype wire

// File: src/brl_setup.sv
// ---------------------------------------------------------------------------
// Line setup
// Axis swap for steep lines, endpoint ordering and delta computation.
// ---------------------------------------------------------------------------
`default_nettype none

module brl_setup (
    input  wire logic [brl_pkg::COORD_W-1:0] start_x,
    input  wire logic [brl_pkg::COORD_W-1:0] start_y,
    input  wire logic [brl_pkg::COORD_W-1:0] end_x,
    input  wire logic [brl_pkg::COORD_W-1:0] end_y,
    output brl_pkg::walk_t                   walk
);

    logic [brl_pkg::COORD_W-1:0] adx, ady;
    logic                        steep;
    logic [brl_pkg::COORD_W-1:0] a0, b0, a1, b1;
    logic [brl_pkg::COORD_W-1:0] ma0, mb0, ma1, mb1;

    always_comb begin
        adx   = (end_x > start_x) ? end_x - start_x : start_x - end_x;
        ady   = (end_y > start_y) ? end_y - start_y : start_y - end_y;
        steep = ady > adx;
        a0    = steep ? start_y : start_x;
        b0    = steep ? start_x : start_y;
        a1    = steep ? end_y   : end_x;
        b1    = steep ? end_x   : end_y;
        // Order so the major coordinate rises.
        if (a0 > a1) begin
            ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
        end else begin
            ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
        end
        walk.steep       = steep;
        walk.dir_up      = mb0 < mb1;
        walk.major_start = ma0;
        walk.major_end   = ma1;
        walk.minor_start = mb0;
        walk.dmaj        = ma1 - ma0;
        walk.dmin        = (mb1 > mb0) ? mb1 - mb0 : mb0 - mb1;
        walk.zero        = (ma1 == ma0);
    end

endmodule

`default_nettype wire

// File: src/brl_step_unit.sv
// ---------------------------------------------------------------------------
// Bresenham step unit
// Error-term update and minor-axis advance for one major-axis step.
// ---------------------------------------------------------------------------
`default_nettype none

module brl_step_unit (
    input  wire logic signed [brl_pkg::ERR_W-1:0]   err,
    input  wire logic        [brl_pkg::COORD_W-1:0] minor,
    input  wire logic        [brl_pkg::COORD_W-1:0] dmaj,
    input  wire logic        [brl_pkg::COORD_W-1:0] dmin,
    input  wire logic                               dir_up,
    output logic signed      [brl_pkg::ERR_W-1:0]   err_out,
    output logic             [brl_pkg::COORD_W-1:0] minor_out
);

    logic signed [brl_pkg::ERR_W-1:0] err_sub;

    always_comb begin
        err_sub = err - $signed({2'b00, dmin});
        if (err_sub < 0) begin
            err_out   = err_sub + $signed({2'b00, dmaj});
            minor_out = dir_up ? minor + 6'd1 : minor - 6'd1;
        end else begin
            err_out   = err_sub;
            minor_out = minor;
        end
    end

endmodule

`default_nettype wire

// File: src/bresenham_line_rasterizer.sv
// ---------------------------------------------------------------------------
// Bresenham line rasterizer
// Walks one line command and streams one pixel-write beat per major step,
// or a single empty beat for a line of no major length.
// The command is captured in ST_IDLE, the walk is loaded in ST_SETUP and
// beats are registered in ST_RUN whenever the output register is free. A
// new command is taken only in ST_IDLE, after the last beat of a line; the
// single step unit is used once per major-axis step.
// Reset: synchronous, active low; canvas registers return to MAX_DIM.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rasterizer_defines.svh"

module bresenham_line_rasterizer #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [brl_pkg::ADDR_W-1:0]        cfg_addr,
    input  wire logic [brl_pkg::DIM_W-1:0]         cfg_wdata,
    // Command stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18],
    // red[31:24], green[39:32], blue[47:40], alpha[55:48]
    input  wire logic [brl_pkg::TDATA_W-1:0]       s_tdata,
    // Pixel stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_index[23:12],
    // out_red[31:24], out_green[39:32], out_blue[47:40], out_alpha[55:48]
    output logic [brl_pkg::TDATA_W-1:0]            m_tdata,
    // write_enable[0]
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    localparam logic [brl_pkg::DIM_W-1:0] MaxDimV = brl_pkg::DIM_W'(MAX_DIM);

    // Canvas registers.
    logic [brl_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [brl_pkg::DIM_W-1:0] eff_w, eff_h;

    // Command held for the whole line.
    logic [brl_pkg::COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [4*brl_pkg::COLOR_W-1:0] color_reg;

    // Sequencer and walk state.
    brl_pkg::state_t state_reg, state_next;
    brl_pkg::walk_t  walk_reg, walk_setup;
    logic [brl_pkg::COORD_W-1:0]      major_reg, minor_reg;
    logic signed [brl_pkg::ERR_W-1:0] err_reg;
    logic signed [brl_pkg::ERR_W-1:0] err_step;
    logic [brl_pkg::COORD_W-1:0]      minor_step;

    // Output register.
    logic                          m_valid_reg;
    logic [brl_pkg::TDATA_W-1:0]   m_data_reg;
    logic                          m_user_reg, m_last_reg;

    logic                          in_beat, out_free, emit;
    logic                          step_last, in_canvas;
    logic [brl_pkg::COORD_W-1:0]   px, py;
    logic [brl_pkg::IDX_W-1:0]     pix_index;

    assign s_tready = (state_reg == brl_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = (state_reg == brl_pkg::ST_RUN) && out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Register values above the largest canvas count as the largest canvas.
    assign eff_w = (width_reg  > MaxDimV) ? MaxDimV : width_reg;
    assign eff_h = (height_reg > MaxDimV) ? MaxDimV : height_reg;

    brl_setup u_setup (
        .start_x (sx_reg),
        .start_y (sy_reg),
        .end_x   (ex_reg),
        .end_y   (ey_reg),
        .walk    (walk_setup)
    );

    brl_step_unit u_step (
        .err       (err_reg),
        .minor     (minor_reg),
        .dmaj      (walk_reg.dmaj),
        .dmin      (walk_reg.dmin),
        .dir_up    (walk_reg.dir_up),
        .err_out   (err_step),
        .minor_out (minor_step)
    );

    // Point of the current step, in canvas orientation, and its address.
    always_comb begin
        px        = walk_reg.steep ? minor_reg : major_reg;
        py        = walk_reg.steep ? major_reg : minor_reg;
        step_last = ({1'b0, major_reg} + 7'd1) == {1'b0, walk_reg.major_end};
        in_canvas = ({1'b0, px} < eff_w) && ({1'b0, py} < eff_h);
        pix_index = brl_pkg::IDX_W'(px) +
                    brl_pkg::IDX_W'(brl_pkg::IDX_W'(py) * brl_pkg::IDX_W'(eff_w));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            brl_pkg::ST_IDLE: begin
                if (in_beat) begin
                    state_next = brl_pkg::ST_SETUP;
                end
            end
            brl_pkg::ST_SETUP: begin
                state_next = brl_pkg::ST_RUN;
            end
            brl_pkg::ST_RUN: begin
                if (emit && (walk_reg.zero || step_last)) begin
                    state_next = brl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= brl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            width_reg   <= MaxDimV;
            height_reg  <= MaxDimV;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_addr == brl_pkg::REG_CANVAS_WIDTH) begin
                    width_reg <= cfg_wdata;
                end else if (cfg_addr == brl_pkg::REG_CANVAS_HEIGHT) begin
                    height_reg <= cfg_wdata;
                end
            end
        end
    end

    // Payload registers: command capture, walk state and the output beat.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            sx_reg    <= s_tdata[5:0];
            sy_reg    <= s_tdata[11:6];
            ex_reg    <= s_tdata[17:12];
            ey_reg    <= s_tdata[23:18];
            color_reg <= s_tdata[55:24];
        end
        if (state_reg == brl_pkg::ST_SETUP) begin
            walk_reg  <= walk_setup;
            major_reg <= walk_setup.major_start;
            minor_reg <= walk_setup.minor_start;
            err_reg   <= $signed({3'b000, walk_setup.dmaj[5:1]});
        end else if (emit) begin
            major_reg <= major_reg + 6'd1;
            minor_reg <= minor_step;
            err_reg   <= err_step;
        end
        if (emit) begin
            if (walk_reg.zero) begin
                // A line of no major length gives one empty closing beat.
                m_data_reg <= '0;
                m_user_reg <= 1'b0;
                m_last_reg <= 1'b1;
            end else begin
                m_data_reg[5:0]   <= px;
                m_data_reg[11:6]  <= py;
                m_data_reg[23:12] <= in_canvas ? pix_index : '0;
                m_data_reg[55:24] <= in_canvas ? color_reg : '0;
                m_user_reg        <= in_canvas;
                m_last_reg        <= step_last;
            end
        end
    end

    // A clipped beat carries neither an address nor a color.
    `BRL_ASSERT_IMP(a_clip_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[55:12] == '0)
    // A written pixel always lies on the effective canvas.
    `BRL_ASSERT_IMP(a_on_canvas, aclk, aresetn, m_tvalid && m_tuser, ({1'b0, m_tdata[5:0]} < eff_w) && ({1'b0, m_tdata[11:6]} < eff_h))
    // Once a command is taken the block stays busy for its setup.
    `BRL_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready && (state_reg == brl_pkg::ST_SETUP))

endmodule

`default_nettype wire

// File: test/bresenham_line_rasterizer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Line rasterizer regression
// Drives line commands through the rasterizer and checks every pixel beat
// against an in-bench Bresenham walk or a typed-in beat, over a range of
// canvas sizes, with bursty command traffic and a stalling pixel sink.
// ---------------------------------------------------------------------------

module bresenham_line_rasterizer_test;

    localparam int MAX_DIM       = 64;
    localparam int COORD_MAX     = MAX_DIM - 1;
    // The walker returns to idle as it registers the last beat of a line, so
    // it is already idle by the time the sink has taken that beat.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_LINES   = 45;
    localparam int FIXED_PHASES  = 7;
    localparam int DIRECTED_ROWS = 24;

    // Register indexes the block does not decode; writes to them must be dropped.
    localparam logic [brl_pkg::ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [brl_pkg::ADDR_W-1:0] REG_SPARE_B = 2'd3;

    // One line command, fields in the order they are packed into s_tdata.
    typedef struct packed {
        logic [brl_pkg::COORD_W-1:0] sx;
        logic [brl_pkg::COORD_W-1:0] sy;
        logic [brl_pkg::COORD_W-1:0] ex;
        logic [brl_pkg::COORD_W-1:0] ey;
        logic [brl_pkg::COLOR_W-1:0] red;
        logic [brl_pkg::COLOR_W-1:0] green;
        logic [brl_pkg::COLOR_W-1:0] blue;
        logic [brl_pkg::COLOR_W-1:0] alpha;
    } line_t;

    // One pixel-write beat as seen on the result side.
    typedef struct packed {
        logic [brl_pkg::COORD_W-1:0] x;
        logic [brl_pkg::COORD_W-1:0] y;
        logic [brl_pkg::IDX_W-1:0]   idx;
        logic                        we;
        logic [brl_pkg::COLOR_W-1:0] red;
        logic [brl_pkg::COLOR_W-1:0] green;
        logic [brl_pkg::COLOR_W-1:0] blue;
        logic [brl_pkg::COLOR_W-1:0] alpha;
        logic                        last;
    } pixel_t;

    // A directed row: canvas to run under, the command, and for the rows whose
    // single beat is obvious, that beat typed in. Colors are 0xRRGGBBAA.
    typedef struct packed {
        logic [brl_pkg::DIM_W-1:0]   w;
        logic [brl_pkg::DIM_W-1:0]   h;
        logic [brl_pkg::COORD_W-1:0] sx;
        logic [brl_pkg::COORD_W-1:0] sy;
        logic [brl_pkg::COORD_W-1:0] ex;
        logic [brl_pkg::COORD_W-1:0] ey;
        logic [31:0]                 rgba;
        logic                        typed;
        logic [brl_pkg::COORD_W-1:0] px;
        logic [brl_pkg::COORD_W-1:0] py;
        logic [brl_pkg::IDX_W-1:0]   idx;
        logic                        we;
        logic [31:0]                 want_rgba;
        logic                        last;
    } plan_row_t;

    // -----------------------------------------------------------------------
    // Block connections. Every input starts at a known value.
    // -----------------------------------------------------------------------
    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [brl_pkg::ADDR_W-1:0]   cfg_addr  = '0;
    logic [brl_pkg::DIM_W-1:0]    cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [brl_pkg::TDATA_W-1:0]  s_tdata   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [brl_pkg::TDATA_W-1:0]  m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    bresenham_line_rasterizer #(
        .MAX_DIM (MAX_DIM)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Predictor state: the bench's own copy of the two canvas registers, and
    // the pixels still owed by the block, oldest first.
    // -----------------------------------------------------------------------
    logic [brl_pkg::DIM_W-1:0] canvas_w = brl_pkg::DIM_W'(MAX_DIM);
    logic [brl_pkg::DIM_W-1:0] canvas_h = brl_pkg::DIM_W'(MAX_DIM);
    pixel_t                    pending_pixels [$];

    int error_count   = 0;
    int beats_checked = 0;
    int beats_clipped = 0;
    int lines_sent    = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;

    // Sink stall pattern state.
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    // Source burst state.
    int burst_left = 0;

    // Directed stimulus. The first rows exercise zero-length commands, the
    // shortest lines at both corners, full-length horizontal, vertical and
    // diagonal lines in both directions, and shallow and steep slopes. The
    // last rows change the canvas: an empty canvas clips everything, an
    // oversize value behaves as the full canvas, and small canvases clip part
    // of a line while the row stride follows the width.
    plan_row_t directed_plan [DIRECTED_ROWS] = '{
        '{64, 64,  0,  0,  0,  0, 32'hFFFFFFFF, 1,  0,  0,    0, 0, 32'h00000000, 1},
        '{64, 64, 63, 63, 63, 63, 32'h12345678, 1,  0,  0,    0, 0, 32'h00000000, 1},
        '{64, 64,  0,  0,  1,  0, 32'h11223344, 1,  0,  0,    0, 1, 32'h11223344, 1},
        '{64, 64, 63, 63, 62, 63, 32'hA5A5A5A5, 1, 62, 63, 4094, 1, 32'hA5A5A5A5, 1},
        '{64, 64,  0,  0, 63,  0, 32'hFF000000, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64,  0,  0,  0, 63, 32'h00FF0000, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64,  0,  0, 63, 63, 32'h0000FF00, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 63,  0,  0, 63, 32'h000000FF, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 63, 63,  0,  0, 32'hAAAAAAAA, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64,  0, 63, 63,  0, 32'h55555555, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 10,  5, 50, 20, 32'h0F0F0F0F, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 50, 20, 10,  5, 32'hF0F0F0F0, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64,  5, 10, 20, 50, 32'h01020408, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 20, 50,  5, 10, 32'h10204080, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 30, 30, 31, 63, 32'h7F7F7F7F, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64,  0, 63, 62, 62, 32'h80808080, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 42, 21, 21, 42, 32'hC3C3C3C3, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64,  1,  2,  3,  1, 32'h3C3C3C3C, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{64, 64, 63,  0, 63,  0, 32'h00000000, 1,  0,  0,    0, 0, 32'h00000000, 1},
        '{64, 64, 21, 42, 42, 21, 32'h55AA55AA, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{ 0,  0,  5,  5,  6,  5, 32'h9ABCDEF0, 1,  5,  5,    0, 0, 32'h00000000, 1},
        '{127, 127, 63, 63, 62, 63, 32'h13579BDF, 1, 62, 63, 4094, 1, 32'h13579BDF, 1},
        '{10,  8,  0,  0, 20, 12, 32'h2468ACE0, 0,  0,  0,    0, 0, 32'h00000000, 0},
        '{ 1, 64,  0,  0,  2, 40, 32'hFEDCBA98, 0,  0,  0,    0, 0, 32'h00000000, 0}
    };

    // Canvas sizes for the first random phases: single pixel, empty width,
    // oversize, single row, odd sizes and an empty height. The rest are drawn
    // at random from the legal range.
    int canvas_plan_w [FIXED_PHASES] = '{1,  0, 127, 64, 17, 65, 40};
    int canvas_plan_h [FIXED_PHASES] = '{1, 40, 127,  1, 64,  3,  0};

    // -----------------------------------------------------------------------
    // Predictor: walks the Bresenham line of one command under the current
    // canvas and appends the beats it must produce.
    // -----------------------------------------------------------------------
    function automatic void rasterize_line(input line_t ln);
        int     a0, b0, a1, b1, t;
        int     adx, ady, dmaj, dmin, err, dir, minor;
        int     px, py, w, h;
        bit     steep, in_canvas;
        pixel_t p;
        a0 = ln.sx;
        b0 = ln.sy;
        a1 = ln.ex;
        b1 = ln.ey;
        // Register values above the largest dimension act as that dimension.
        w = (canvas_w > MAX_DIM) ? MAX_DIM : canvas_w;
        h = (canvas_h > MAX_DIM) ? MAX_DIM : canvas_h;
        adx = (a1 > a0) ? a1 - a0 : a0 - a1;
        ady = (b1 > b0) ? b1 - b0 : b0 - b1;
        // Walk along y when the line is steeper than 45 degrees.
        steep = ady > adx;
        if (steep) begin
            t = a0; a0 = b0; b0 = t;
            t = a1; a1 = b1; b1 = t;
        end
        // Always walk with the major coordinate rising.
        if (a0 > a1) begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
        end
        dmaj  = a1 - a0;
        dmin  = (b1 > b0) ? b1 - b0 : b0 - b1;
        err   = dmaj / 2;
        dir   = (b0 < b1) ? 1 : -1;
        minor = b0;
        if (dmaj == 0) begin
            // A point-sized command still closes its frame with one empty beat.
            p      = '0;
            p.last = 1'b1;
            pending_pixels.push_back(p);
            return;
        end
        // The far endpoint is not drawn.
        for (int major = a0; major < a1; major++) begin
            px        = steep ? minor : major;
            py        = steep ? major : minor;
            in_canvas = (px < w) && (py < h);
            p.x       = brl_pkg::COORD_W'(px);
            p.y       = brl_pkg::COORD_W'(py);
            p.idx     = in_canvas ? brl_pkg::IDX_W'(px + py * w) : '0;
            p.we      = in_canvas;
            p.red     = in_canvas ? ln.red   : '0;
            p.green   = in_canvas ? ln.green : '0;
            p.blue    = in_canvas ? ln.blue  : '0;
            p.alpha   = in_canvas ? ln.alpha : '0;
            p.last    = (major + 1 == a1);
            pending_pixels.push_back(p);
            err -= dmin;
            if (err < 0) begin
                minor += dir;
                err   += dmaj;
            end
        end
    endfunction

    function automatic string pixel_text(input pixel_t p);
        return $sformatf("x=%0d y=%0d index=%0d we=%0b rgba=%02h%02h%02h%02h last=%0b",
                         p.x, p.y, p.idx, p.we, p.red, p.green, p.blue, p.alpha, p.last);
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    function automatic logic [brl_pkg::COORD_W-1:0] clamp_coord(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > COORD_MAX) begin
            return brl_pkg::COORD_W'(COORD_MAX);
        end
        return brl_pkg::COORD_W'(v);
    endfunction

    // Random command. Most are free endpoints or short strokes; the rest are
    // axis-aligned, near-diagonal or zero-length, so every octant and the
    // degenerate case keep turning up.
    function automatic line_t make_line();
        line_t ln;
        int    kind, d;
        ln.sx = brl_pkg::COORD_W'($urandom);
        ln.sy = brl_pkg::COORD_W'($urandom);
        ln.ex = brl_pkg::COORD_W'($urandom);
        ln.ey = brl_pkg::COORD_W'($urandom);
        {ln.red, ln.green, ln.blue, ln.alpha} = $urandom;
        kind = $urandom_range(0, 9);
        case (kind)
            4, 5, 6: begin
                ln.ex = clamp_coord(int'(ln.sx) + int'($urandom_range(0, 14)) - 7);
                ln.ey = clamp_coord(int'(ln.sy) + int'($urandom_range(0, 14)) - 7);
            end
            7: begin
                if ($urandom_range(0, 1) == 0) begin
                    ln.ey = ln.sy;
                end else begin
                    ln.ex = ln.sx;
                end
            end
            8: begin
                d     = $urandom_range(0, COORD_MAX);
                ln.ex = clamp_coord(($urandom_range(0, 1) == 0) ? ln.sx + d : ln.sx - d);
                ln.ey = clamp_coord(($urandom_range(0, 1) == 0) ? ln.sy + d : ln.sy - d);
            end
            9: begin
                ln.ex = ln.sx;
                ln.ey = ln.sy;
            end
            default: begin
            end
        endcase
        return ln;
    endfunction

    // -----------------------------------------------------------------------
    // Configuration writes. The bench's register copy changes at the same
    // edge as the block's. The write enable is low again before the task
    // returns, so back-to-back calls never re-drive it within one time step.
    // -----------------------------------------------------------------------
    task automatic write_reg(input logic [brl_pkg::ADDR_W-1:0] index,
                             input logic [brl_pkg::DIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (index)
            brl_pkg::REG_CANVAS_WIDTH: begin
                canvas_w = value;
            end
            brl_pkg::REG_CANVAS_HEIGHT: begin
                canvas_h = value;
            end
            default: begin
            end
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // Presents one command and returns at the edge where it is taken. With
    // keep set, valid stays high so the next command follows without a gap.
    task automatic issue_line(input line_t ln, input bit keep);
        s_tdata  <= {ln.alpha, ln.blue, ln.green, ln.red, ln.ey, ln.ex, ln.sy, ln.sx};
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        lines_sent++;
        if (!keep) begin
            s_tvalid <= 1'b0;
        end
    endtask

    // Holds until every owed pixel has come out, then lets the walker settle.
    task automatic wait_drained();
        while (pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // -----------------------------------------------------------------------
    // Pixel sink: checks each accepted beat against the oldest owed pixel and
    // then decides its ready for the next cycle. The sink switches between
    // always ready, randomly ready and occasional stalls.
    // -----------------------------------------------------------------------
    task automatic check_pixel();
        pixel_t seen, want;
        seen = {m_tdata[5:0], m_tdata[11:6], m_tdata[23:12], m_tuser,
                m_tdata[31:24], m_tdata[39:32], m_tdata[47:40], m_tdata[55:48], m_tlast};
        beats_checked++;
        if (seen.we !== 1'b1) begin
            beats_clipped++;
        end
        if (pending_pixels.size() == 0) begin
            report_error($sformatf("pixel beat with none owed: %s", pixel_text(seen)));
        end else begin
            want = pending_pixels.pop_front();
            if (seen !== want) begin
                report_error($sformatf("pixel mismatch\n  expected %s\n  actual   %s",
                                       pixel_text(want), pixel_text(seen)));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_pixel();
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left = $urandom_range(1, 8);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog, sized far above the slowest legal run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[%0t] ERROR: timed out with %0d pixels still owed",
                     $realtime, pending_pixels.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------
    initial begin
        line_t     ln;
        plan_row_t row;
        pixel_t    typed_pixel;
        int        gap;
        bit        keep;
        logic [brl_pkg::DIM_W-1:0] new_w, new_h;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Rows that need a different canvas wait for the
        // walker to go idle before the registers are rewritten. Valid drops
        // between rows.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_plan[i];
            if (row.w != canvas_w || row.h != canvas_h) begin
                wait_drained();
                write_reg(brl_pkg::REG_CANVAS_WIDTH, row.w);
                write_reg(brl_pkg::REG_CANVAS_HEIGHT, row.h);
            end
            ln = '{row.sx, row.sy, row.ex, row.ey,
                   row.rgba[31:24], row.rgba[23:16], row.rgba[15:8], row.rgba[7:0]};
            issue_line(ln, 1'b0);
            if (row.typed) begin
                typed_pixel = '{row.px, row.py, row.idx, row.we,
                                row.want_rgba[31:24], row.want_rgba[23:16],
                                row.want_rgba[15:8], row.want_rgba[7:0], row.last};
                pending_pixels.push_back(typed_pixel);
            end else begin
                rasterize_line(ln);
            end
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end

        // Random part: one canvas per phase, registers written only once the
        // previous phase has fully drained.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph < FIXED_PHASES) begin
                new_w = brl_pkg::DIM_W'(canvas_plan_w[ph]);
                new_h = brl_pkg::DIM_W'(canvas_plan_h[ph]);
            end else begin
                new_w = brl_pkg::DIM_W'($urandom_range(1, MAX_DIM));
                new_h = brl_pkg::DIM_W'($urandom_range(1, MAX_DIM));
            end
            write_reg(brl_pkg::REG_CANVAS_WIDTH, new_w);
            write_reg(brl_pkg::REG_CANVAS_HEIGHT, new_h);
            // Writes to undecoded indexes must leave the canvas alone.
            if (ph == 3) begin
                write_reg(REG_SPARE_A, brl_pkg::DIM_W'($urandom));
                write_reg(REG_SPARE_B, brl_pkg::DIM_W'($urandom));
            end
            for (int k = 0; k < PHASE_LINES; k++) begin
                ln = make_line();
                // Commands come in bursts; now and then a long burst runs
                // with no gaps at all.
                if (burst_left == 0) begin
                    gap        = $urandom_range(1, 12);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 8);
                end else begin
                    gap = 0;
                    burst_left--;
                end
                keep = (gap == 0) && (k != PHASE_LINES - 1) && (k != PHASE_LINES / 2);
                issue_line(ln, keep);
                rasterize_line(ln);
                if (k == PHASE_LINES / 2) begin
                    // Mid-phase, the source stops until the sink has seen
                    // every owed pixel.
                    wait_drained();
                end else if (!keep) begin
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d line commands across %0d register writes; checked %0d pixel beats",
                 lines_sent, reg_writes, beats_checked);
        $display("(%0d clipped), on canvases from empty and single pixel up to oversize.",
                 beats_clipped);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors, %0d pixels still owed", error_count, pending_pixels.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
